### rtl/rsws_pkg.sv
// Package for the range scan window smoother.
// Holds the request and result payload types and the state machine encodings.
// It has no dependencies and is compiled before every other file of the block.
`default_nettype none

package rsws_pkg;

    localparam int RANGE_BITS = 16;

    typedef struct packed {
        logic [RANGE_BITS-1:0] range_mm;
        logic                  sample_valid;
        logic                  last_sample;
    } t_in_item;

    typedef struct packed {
        logic [RANGE_BITS-1:0] smoothed_mm;
        logic                  any_valid;
        logic                  last_result;
    } t_out_item;

    typedef enum logic [0:0] {
        F_IDLE,
        F_STEP
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_HOLD
    } t_back_state;

endpackage

`default_nettype wire

### rtl/rsws_front.sv
// Front end of the range scan window smoother: tap window, running sum and tap count.
// It issues one divide job per emitted result, including the flush at scan end.
// Depends on rsws_pkg.
`default_nettype none

module rsws_front #(
    parameter int HALF_TAPS = 2,
    localparam int WIN        = 2 * HALF_TAPS + 1,
    localparam int SUMW       = rsws_pkg::RANGE_BITS + $clog2(WIN),
    localparam int CNTW       = $clog2(WIN + 1),
    localparam int JOB_W      = SUMW + CNTW + rsws_pkg::RANGE_BITS + 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire rsws_pkg::t_in_item i_in_data,
    output logic                    o_push,
    output logic [JOB_W-1:0]        o_job,
    input  wire logic               i_full
);
    import rsws_pkg::*;

    localparam int FW = $clog2(HALF_TAPS + 1);

    t_front_state          r_state, n_state;
    logic [RANGE_BITS-1:0] r_taps [WIN];
    logic [WIN-1:0]        r_tvld;
    logic [SUMW-1:0]       r_sum;
    logic [CNTW-1:0]       r_cnt;
    logic [FW-1:0]         r_fill, n_fill;
    logic                  r_emit, n_emit;
    logic                  r_mark, n_mark;
    logic                  r_flush, n_flush;
    logic [FW-1:0]         r_pend, n_pend;
    logic [FW-1:0]         r_step, n_step;

    logic                  shift_en;
    logic [RANGE_BITS-1:0] shift_val;
    logic                  shift_vld;
    logic                  win_clr;
    logic [SUMW-1:0]       sum_out;
    logic [SUMW-1:0]       sum_in;
    logic                  step_done;

    assign step_done = !r_emit || !i_full;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    n_state = F_STEP;
                end
            end
            F_STEP: begin
                if (step_done && (!r_flush || r_step == FW'(HALF_TAPS))) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == F_IDLE);
        o_push     = 1'b0;
        shift_en   = 1'b0;
        shift_val  = i_in_data.range_mm;
        shift_vld  = i_in_data.sample_valid;
        win_clr    = 1'b0;
        n_fill     = r_fill;
        n_emit     = r_emit;
        n_mark     = r_mark;
        n_flush    = r_flush;
        n_pend     = r_pend;
        n_step     = r_step;
        case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    shift_en = 1'b1;
                    n_emit   = (r_fill == FW'(HALF_TAPS));
                    n_mark   = 1'b0;
                    n_flush  = i_in_data.last_sample;
                    n_step   = '0;
                    if (r_fill == FW'(HALF_TAPS)) begin
                        n_pend = FW'(HALF_TAPS);
                    end else begin
                        n_fill = r_fill + FW'(1);
                        n_pend = r_fill + FW'(1);
                    end
                end
            end
            F_STEP: begin
                o_push = r_emit && !i_full;
                if (step_done) begin
                    if (r_flush) begin
                        if (r_step == FW'(HALF_TAPS)) begin
                            win_clr = 1'b1;
                            n_fill  = '0;
                            n_flush = 1'b0;
                            n_emit  = 1'b0;
                        end else begin
                            shift_en  = 1'b1;
                            shift_val = '0;
                            shift_vld = 1'b0;
                            n_emit    = ({1'b0, r_step} + {1'b0, r_pend})
                                        >= (FW + 1)'(HALF_TAPS);
                            n_mark    = (r_step == FW'(HALF_TAPS - 1));
                            n_step    = r_step + FW'(1);
                        end
                    end else begin
                        n_emit = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign sum_out = r_tvld[0] ? SUMW'(r_taps[0]) : '0;
    assign sum_in  = shift_vld ? SUMW'(shift_val) : '0;
    assign o_job   = {r_sum, r_cnt, r_taps[HALF_TAPS], r_mark};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_tvld  <= '0;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_fill  <= '0;
            r_emit  <= 1'b0;
            r_mark  <= 1'b0;
            r_flush <= 1'b0;
            r_pend  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_emit  <= n_emit;
            r_mark  <= n_mark;
            r_flush <= n_flush;
            r_pend  <= n_pend;
            r_step  <= n_step;
            if (win_clr) begin
                r_tvld <= '0;
                r_sum  <= '0;
                r_cnt  <= '0;
            end else if (shift_en) begin
                r_tvld <= {shift_vld, r_tvld[WIN-1:1]};
                r_sum  <= r_sum - sum_out + sum_in;
                r_cnt  <= r_cnt - CNTW'(r_tvld[0]) + CNTW'(shift_vld);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int i = 0; i < WIN - 1; i++) begin
                r_taps[i] <= r_taps[i+1];
            end
            r_taps[WIN-1] <= shift_val;
        end
    end

    a_cnt_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == CNTW'($countones(r_tvld)))
        else $error("Tap count disagrees with the window valid bits.");

    a_idle_not_flushing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_IDLE) |-> (!r_flush && r_fill <= FW'(HALF_TAPS)))
        else $error("Front end is idle with a flush pending or fill count out of range.");

endmodule

`default_nettype wire

### rtl/rsws_queue.sv
// Short job queue between the front end and the divider of the window smoother.
// Register based, one write and one read port; no package dependencies.
`default_nettype none

module rsws_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("Job queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("Job queue read while empty.");

endmodule

`default_nettype wire

### rtl/rsws_back.sv
// Back end of the range scan window smoother: serial restoring divider and result register.
// Takes jobs from the queue and produces one result per job. Depends on rsws_pkg.
`default_nettype none

module rsws_back #(
    parameter int HALF_TAPS = 2,
    localparam int WIN        = 2 * HALF_TAPS + 1,
    localparam int SUMW       = rsws_pkg::RANGE_BITS + $clog2(WIN),
    localparam int CNTW       = $clog2(WIN + 1),
    localparam int JOB_W      = SUMW + CNTW + rsws_pkg::RANGE_BITS + 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_empty,
    input  wire logic [JOB_W-1:0]    i_job,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output rsws_pkg::t_out_item      o_out_data
);
    import rsws_pkg::*;

    localparam int CTRW = $clog2(SUMW);

    t_back_state           r_state, n_state;
    logic [SUMW-1:0]       r_dvd;
    logic [CNTW-1:0]       r_div;
    logic [CNTW-1:0]       r_rem;
    logic [CTRW-1:0]       r_ctr;
    logic [RANGE_BITS-1:0] r_centre;
    logic                  r_last;
    logic                  r_any;
    logic                  r_ovld;
    t_out_item             r_odata;

    logic [SUMW-1:0]       job_sum;
    logic [CNTW-1:0]       job_cnt;
    logic [RANGE_BITS-1:0] job_centre;
    logic                  job_last;
    logic [CNTW:0]         rem_sh;
    logic [CNTW:0]         diff;
    logic                  qbit;
    logic                  load_out;

    assign job_sum    = i_job[JOB_W-1 -: SUMW];
    assign job_cnt    = i_job[RANGE_BITS+1 +: CNTW];
    assign job_centre = i_job[1 +: RANGE_BITS];
    assign job_last   = i_job[0];

    assign rem_sh = {r_rem, r_dvd[SUMW-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign qbit   = (rem_sh >= {1'b0, r_div});

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = (job_cnt == '0) ? B_HOLD : B_DIV;
                end
            end
            B_DIV: begin
                if (r_ctr == CTRW'(SUMW - 1)) begin
                    n_state = B_HOLD;
                end
            end
            B_HOLD: begin
                if (!r_ovld || i_out_ready) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == B_IDLE) && !i_empty;
        load_out = (r_state == B_HOLD) && (!r_ovld || i_out_ready);
    end

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dvd    <= job_sum;
            r_div    <= job_cnt;
            r_rem    <= '0;
            r_ctr    <= '0;
            r_centre <= job_centre;
            r_last   <= job_last;
            r_any    <= (job_cnt != '0);
        end else if (r_state == B_DIV) begin
            r_dvd <= {r_dvd[SUMW-2:0], qbit};
            r_rem <= qbit ? diff[CNTW-1:0] : rem_sh[CNTW-1:0];
            r_ctr <= r_ctr + CTRW'(1);
        end
        if (load_out) begin
            r_odata.smoothed_mm <= r_any ? r_dvd[RANGE_BITS-1:0] : r_centre;
            r_odata.any_valid   <= r_any;
            r_odata.last_result <= r_last;
        end
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_div != '0 && r_any))
        else $error("Divider running with a zero tap count.");

endmodule

`default_nettype wire

### rtl/range_scan_window_smoother.sv
// Top level of the range scan window smoother.
// Connects rsws_front, rsws_queue and rsws_back; payload types come from rsws_pkg.
// Each range sample is replaced by the truncated mean of the valid samples in a centered
// window of 2*HALF_TAPS+1 taps, restricted to the current scan; with no valid tap the raw
// center sample is passed and any_valid is low. Results lag the requests by HALF_TAPS, and
// the request marked last flushes the remaining results, the final one carrying last_result.
// The front end takes a request in F_IDLE and handles it in F_STEP, stalling while the
// job queue is full. Each result with a valid tap costs the back end one bit per cycle of a
// restoring divide over the 16+clog2(taps) bit window sum, and that divider sets the
// sustained rate. A two entry job queue lets the front end run ahead while it works.
`default_nettype none

module range_scan_window_smoother #(
    parameter int HALF_TAPS = 2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire rsws_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output rsws_pkg::t_out_item      o_out_data
);
    import rsws_pkg::*;

    localparam int WIN         = 2 * HALF_TAPS + 1;
    localparam int SUMW        = RANGE_BITS + $clog2(WIN);
    localparam int CNTW        = $clog2(WIN + 1);
    localparam int JOB_W       = SUMW + CNTW + RANGE_BITS + 1;
    localparam int QUEUE_DEPTH = 2;

    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    logic [JOB_W-1:0] job_in;
    logic [JOB_W-1:0] job_out;

    rsws_front #(
        .HALF_TAPS(HALF_TAPS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_job      (job_in),
        .i_full     (full)
    );

    rsws_queue #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (empty)
    );

    rsws_back #(
        .HALF_TAPS(HALF_TAPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for range_scan_window_smoother.
// Drives range samples and checks every result against a scan-aware predictor of the
// centered mean or a typed directed row; depends only on rsws_pkg and the RTL of the block.

module tb_top;
    import rsws_pkg::*;

    localparam int HALF = 2;
    localparam int TAPS = 2 * HALF + 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_DIRECTED = 20;
    localparam int N_PER_PHASE = 30;

    typedef struct packed {
        t_in_item  req;
        logic      typed;
        logic [1:0] n_res;
        t_out_item res_a;
        t_out_item res_b;
    } t_directed_row;

    // Rows marked typed carry their results; the rest are predicted.
    localparam t_directed_row DIRECTED [N_DIRECTED] = '{
        '{'{16'hFFFF, 1'b1, 1'b1}, 1'b1, 2'd1, '{16'hFFFF, 1'b1, 1'b1}, '0},
        '{'{16'h1234, 1'b0, 1'b1}, 1'b1, 2'd1, '{16'h1234, 1'b0, 1'b1}, '0},
        '{'{16'h0000, 1'b1, 1'b1}, 1'b1, 2'd1, '{16'h0000, 1'b1, 1'b1}, '0},
        '{'{16'hFFFF, 1'b1, 1'b0}, 1'b1, 2'd0, '0, '0},
        '{'{16'hFFFF, 1'b1, 1'b1}, 1'b1, 2'd2, '{16'hFFFF, 1'b1, 1'b0},
            '{16'hFFFF, 1'b1, 1'b1}},
        '{'{16'h0001, 1'b1, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{16'h0002, 1'b1, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{16'h0003, 1'b1, 1'b1}, 1'b0, 2'd0, '0, '0},
        '{'{16'hFFFF, 1'b1, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{16'hFFFF, 1'b1, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{16'h0000, 1'b1, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{16'h1111, 1'b0, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{16'h2222, 1'b0, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{16'h3333, 1'b0, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{16'h4444, 1'b0, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{16'h5555, 1'b0, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{16'hAAAA, 1'b1, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{16'h5555, 1'b1, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{16'h8001, 1'b0, 1'b0}, 1'b0, 2'd0, '0, '0},
        '{'{16'h7FFE, 1'b1, 1'b1}, 1'b0, 2'd0, '0, '0}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    logic [RANGE_BITS-1:0] win_range [TAPS] = '{default: '0};
    logic                  win_ok [TAPS] = '{default: 1'b0};
    int unsigned           fill_cnt = 0;
    t_out_item             step_results [$];
    t_out_item             smoothed_q [$];

    int          send_idle_pct = 23;
    int          recv_idle_pct = 60;
    bit          failed = 1'b0;
    int unsigned cycle_cnt = 0;

    range_scan_window_smoother #(.HALF_TAPS(HALF)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void shift_tap(logic [RANGE_BITS-1:0] range_mm, logic ok);
        for (int i = 0; i < TAPS - 1; i++) begin
            win_range[i] = win_range[i + 1];
            win_ok[i]    = win_ok[i + 1];
        end
        win_range[TAPS - 1] = range_mm;
        win_ok[TAPS - 1]    = ok;
    endfunction

    function automatic t_out_item window_mean(logic is_last);
        logic [RANGE_BITS+2:0] tap_sum;
        int unsigned           tap_cnt;
        t_out_item             res;
        tap_sum = '0;
        tap_cnt = 0;
        for (int i = 0; i < TAPS; i++) begin
            if (win_ok[i]) begin
                tap_sum += (RANGE_BITS + 3)'(win_range[i]);
                tap_cnt++;
            end
        end
        res.smoothed_mm = (tap_cnt != 0) ?
            RANGE_BITS'(tap_sum / (RANGE_BITS + 3)'(tap_cnt)) : win_range[HALF];
        res.any_valid   = (tap_cnt != 0);
        res.last_result = is_last;
        return res;
    endfunction

    // Fills step_results with what one request produces and advances the window.
    function automatic void smooth_sample(t_in_item req);
        logic        filling;
        int unsigned pending;
        step_results.delete();
        shift_tap(req.range_mm, req.sample_valid);
        filling = (fill_cnt < HALF);
        if (filling) begin
            fill_cnt++;
        end else begin
            step_results.insert(step_results.size(), window_mean(1'b0));
        end
        if (req.last_sample) begin
            pending = filling ? fill_cnt : HALF;
            for (int t = 0; t < HALF; t++) begin
                shift_tap('0, 1'b0);
                if (t + pending >= HALF) begin
                    step_results.insert(step_results.size(), window_mean(t == HALF - 1));
                end
            end
            win_range = '{default: '0};
            win_ok    = '{default: 1'b0};
            fill_cnt  = 0;
        end
    endfunction

    // Called at a rising edge; returns at the rising edge where the request is taken.
    task automatic send_request(t_directed_row row);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= row.req;
        do @(negedge i_clk); while (!o_in_ready);
        smooth_sample(row.req);
        if (row.typed) begin
            if (row.n_res > 0) smoothed_q.insert(smoothed_q.size(), row.res_a);
            if (row.n_res > 1) smoothed_q.insert(smoothed_q.size(), row.res_b);
        end else begin
            foreach (step_results[i]) smoothed_q.insert(smoothed_q.size(), step_results[i]);
        end
        @(posedge i_clk);
    endtask

    function automatic t_directed_row random_row(logic is_last);
        t_directed_row row;
        row = '0;
        case ($urandom_range(7))
            0: row.req.range_mm = '0;
            1: row.req.range_mm = '1;
            default: row.req.range_mm = RANGE_BITS'($urandom_range(0, 65535));
        endcase
        row.req.sample_valid = ($urandom_range(99) < 75);
        row.req.last_sample  = is_last;
        return row;
    endfunction

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(negedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (smoothed_q.size() == 0) begin
                $error("unexpected result: smoothed_mm %0h any_valid %0b last_result %0b",
                       o_out_data.smoothed_mm, o_out_data.any_valid, o_out_data.last_result);
                failed = 1'b1;
            end else begin
                want = smoothed_q.pop_front();
                if (o_out_data.smoothed_mm !== want.smoothed_mm) begin
                    $error("smoothed_mm: expected %0h, actual %0h",
                           want.smoothed_mm, o_out_data.smoothed_mm);
                    failed = 1'b1;
                end
                if (o_out_data.any_valid !== want.any_valid) begin
                    $error("any_valid: expected %0b, actual %0b",
                           want.any_valid, o_out_data.any_valid);
                    failed = 1'b1;
                end
                if (o_out_data.last_result !== want.last_result) begin
                    $error("last_result: expected %0b, actual %0b",
                           want.last_result, o_out_data.last_result);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        int scan_left;
        scan_left = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_request(DIRECTED[r]);
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 60 : 0;
            recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 23 : 0;
            for (int n = 0; n < N_PER_PHASE; n++) begin
                if (scan_left == 0) begin
                    scan_left = ($urandom_range(9) == 0) ? $urandom_range(11, 24)
                                                         : $urandom_range(1, 8);
                end
                send_request(random_row(scan_left == 1));
                scan_left--;
            end
        end
        // Close any scan still open so that its results are flushed.
        if (scan_left > 0) begin
            send_request(random_row(1'b1));
        end
        i_in_valid <= 1'b0;

        while (smoothed_q.size() != 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);

        if (!failed && smoothed_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
rtl/rsws_pkg.sv
rtl/rsws_front.sv
rtl/rsws_queue.sv
rtl/rsws_back.sv
rtl/range_scan_window_smoother.sv
sim/tb_top.sv
